// ===== hdl/e2cd_pkg.sv =====
// shared types, constants and tables for the epoch to civil date unit
// no dependencies; used by epoch_to_civil_date_unit and e2cd_checker
package e2cd_pkg;

  // port widths and stage count
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgW     = 33;
  localparam int unsigned Stages   = 12;

  localparam logic [CfgW-1:0] MaxEpochReset = 33'd4102444799;

  // calendar constants
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [19:0] DayShift    = 20'd719468;
  localparam logic [19:0] DaysPerEra  = 20'd146097;
  localparam logic [17:0] LastDoe     = 18'd146096;
  localparam logic [17:0] DaysPerCent = 18'd36524;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [11:0] YearsPerEra = 12'd400;
  localparam logic [11:0] YearBase    = 12'd1900;

  // reciprocals: for x below 2**n, x / d == (x * mul) >> (n + clog2(d))
  // with mul = floor(2**(n + clog2(d)) / d) + 1

  // whole days: (sec >> 7) / 675, sec >> 7 below 2**26
  localparam int unsigned DaySh  = 26 + $clog2(675);
  localparam logic [26:0] DayMul = 27'((64'd1 << DaySh) / 64'd675 + 64'd1);

  // weekday: (days + 4) / 7, below 2**17
  localparam int unsigned WdSh  = 17 + $clog2(7);
  localparam logic [17:0] WdMul = 18'((64'd1 << WdSh) / 64'd7 + 64'd1);

  // hour: rem / 3600, below 2**17
  localparam int unsigned HourSh  = 17 + $clog2(3600);
  localparam logic [17:0] HourMul = 18'((64'd1 << HourSh) / 64'd3600 + 64'd1);

  // minute: (rem % 3600) / 60, below 2**12
  localparam int unsigned MinSh  = 12 + $clog2(60);
  localparam logic [12:0] MinMul = 13'((64'd1 << MinSh) / 64'd60 + 64'd1);

  // leap correction: doe / 1460, below 2**18
  localparam int unsigned LeapSh  = 18 + $clog2(1460);
  localparam logic [18:0] LeapMul = 19'((64'd1 << LeapSh) / 64'd1460 + 64'd1);

  // year of era: t / 365, below 2**18
  localparam int unsigned YoeSh  = 18 + $clog2(365);
  localparam logic [18:0] YoeMul = 19'((64'd1 << YoeSh) / 64'd365 + 64'd1);

  // march-based month: (5 * doy + 2) / 153, below 2**11
  localparam int unsigned MonSh  = 11 + $clog2(153);
  localparam logic [11:0] MonMul = 12'((64'd1 << MonSh) / 64'd153 + 64'd1);

  // time of day and weekday, carried down the pipe
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
  } hms_t;

  // first day of year (march based) for each march-based month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/epoch_to_civil_date_unit.sv =====
// epoch seconds to civil utc date and time, twelve register stages
// each accepted epoch passes through stages 1 to 11 in order, then the output register
// throughput: one epoch per cycle; each stage holds its item until the next frees
// the last stage is the output register; bubbles close up under a stall
// reset (rst_n low, synchronous) empties the pipe and loads max_epoch 4102444799
// depends on e2cd_pkg
module epoch_to_civil_date_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [e2cd_pkg::InDataW-1:0]       in_tdata,   // [63:0] epoch_seconds
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [8:0] years_since_1900, [12:9] month_index, [17:13] day_of_month,
  // [22:18] hour_of_day, [28:23] minute_of_hour, [34:29] second_of_minute,
  // [37:35] weekday, [39:38] zero
  output logic [e2cd_pkg::OutDataW-1:0]      out_tdata,
  output logic                               out_tuser,  // [0] status
  input  logic                               cfg_we,
  input  logic [e2cd_pkg::CfgW-1:0]          cfg_wdata   // max_epoch
);

  localparam int unsigned NSt = e2cd_pkg::Stages;

  logic [e2cd_pkg::CfgW-1:0] max_epoch_r;
  logic [NSt:1]              vld_r, vld_nxt, vld_in;
  logic [NSt+1:1]            adv;

  // stage registers
  logic        s1_err_r;  logic [32:0] s1_sec_r;
  logic        s2_err_r;  logic [32:0] s2_sec_r;  logic [16:0] s2_days_r;
  logic        s3_err_r;  logic [16:0] s3_rem_r;  logic [19:0] s3_z_r;
  logic [16:0] s3_dp4_r;  logic [13:0] s3_wdq_r;
  logic        s4_err_r;  logic [16:0] s4_rem_r;  logic [19:0] s4_z_r;
  logic [2:0]  s4_era_r;  logic [4:0]  s4_hour_r; logic [2:0]  s4_wd_r;
  logic        s5_err_r;  logic [17:0] s5_doe_r;  logic [2:0]  s5_era_r;
  logic [11:0] s5_r2_r;   logic [4:0]  s5_hour_r; logic [2:0]  s5_wd_r;
  logic        s6_err_r;  logic [17:0] s6_doe_r;  logic [2:0]  s6_era_r;
  logic [6:0]  s6_q4y_r;  logic [2:0]  s6_qc_r;   logic        s6_last_r;
  logic [11:0] s6_r2_r;   logic [5:0]  s6_min_r;  logic [4:0]  s6_hour_r;
  logic [2:0]  s6_wd_r;
  logic        s7_err_r;  logic [17:0] s7_doe_r;  logic [2:0]  s7_era_r;
  logic [17:0] s7_t_r;    e2cd_pkg::hms_t s7_hms_r;
  logic        s8_err_r;  logic [17:0] s8_doe_r;  logic [2:0]  s8_era_r;
  logic [8:0]  s8_yoe_r;  e2cd_pkg::hms_t s8_hms_r;
  logic        s9_err_r;  logic [17:0] s9_doe_r;  logic [17:0] s9_yc_r;
  logic [11:0] s9_yr_r;   e2cd_pkg::hms_t s9_hms_r;
  logic        s10_err_r; logic [8:0]  s10_doy_r; logic [11:0] s10_yr_r;
  e2cd_pkg::hms_t s10_hms_r;
  logic        s11_err_r; logic [8:0]  s11_doy_r; logic [3:0]  s11_mp_r;
  logic [11:0] s11_yr_r;  e2cd_pkg::hms_t s11_hms_r;
  logic [e2cd_pkg::OutDataW-1:0] out_tdata_r;
  logic                          out_tuser_r;

  // next values
  logic        s1_err_nxt;
  logic [52:0] day_prod;
  logic [16:0] s2_days_nxt;
  logic [33:0] rem_full;
  logic [16:0] s3_dp4_nxt;
  logic [34:0] wd_prod;
  logic [2:0]  s4_era_nxt;
  logic [34:0] hour_prod;
  logic [16:0] wd_full;
  logic [19:0] doe_full;
  logic [16:0] r2_full;
  logic [36:0] q4y_prod;
  logic [2:0]  s6_qc_nxt;
  logic [24:0] min_prod;
  logic [17:0] s7_t_nxt;
  logic [11:0] sec_full;
  e2cd_pkg::hms_t s7_hms_nxt;
  logic [36:0] yoe_prod;
  logic [1:0]  cent;
  logic [17:0] s9_yc_nxt;
  logic [11:0] s9_yr_nxt;
  logic [10:0] mon_arg;
  logic [22:0] mon_prod;
  logic [8:0]  day_full;
  logic [3:0]  month_nxt;
  logic [11:0] year_adj;
  logic [8:0]  years_nxt;
  logic [e2cd_pkg::OutDataW-1:0] out_tdata_nxt;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_epoch_r <= e2cd_pkg::MaxEpochReset;
    end else if (cfg_we) begin
      max_epoch_r <= cfg_wdata;
    end
  end

  // stage advance: a stage loads when empty or when its item moves on
  assign vld_in = {vld_r[NSt-1:1], in_tvalid};

  always_comb begin
    adv[NSt+1] = out_tready;
    for (int k = NSt; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    for (int k = 1; k <= NSt; k++) begin
      vld_nxt[k] = adv[k] ? vld_in[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = adv[1];
  assign out_tvalid = vld_r[NSt];
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // stage 1: range check
  assign s1_err_nxt = in_tdata[63] || (|in_tdata[62:33]) || (in_tdata[32:0] > max_epoch_r);

  // stage 2: whole days
  assign day_prod    = 53'(s1_sec_r[32:7]) * 53'(e2cd_pkg::DayMul);
  assign s2_days_nxt = day_prod[e2cd_pkg::DaySh +: 17];

  // stage 3: seconds of day, shifted day count, weekday quotient
  assign rem_full   = 34'(s2_sec_r) - 34'(s2_days_r) * 34'(e2cd_pkg::SecsPerDay);
  assign s3_dp4_nxt = s2_days_r + 17'd4;
  assign wd_prod    = 35'(s3_dp4_nxt) * 35'(e2cd_pkg::WdMul);

  // stage 4: era, hour, weekday
  always_comb begin
    s4_era_nxt = '0;
    for (int k = 1; k <= 5; k++) begin
      s4_era_nxt = s4_era_nxt + 3'(s3_z_r >= 20'(k * e2cd_pkg::DaysPerEra));
    end
  end
  assign hour_prod = 35'(s3_rem_r) * 35'(e2cd_pkg::HourMul);
  assign wd_full   = s3_dp4_r - 17'(s3_wdq_r) * 17'd7;

  // stage 5: day of era, seconds of hour
  assign doe_full = s4_z_r - 20'(s4_era_r) * e2cd_pkg::DaysPerEra;
  assign r2_full  = s4_rem_r - 17'(s4_hour_r) * 17'(e2cd_pkg::SecsPerHour);

  // stage 6: leap corrections, minute
  assign q4y_prod = 37'(s5_doe_r) * 37'(e2cd_pkg::LeapMul);
  always_comb begin
    s6_qc_nxt = '0;
    for (int k = 1; k <= 4; k++) begin
      s6_qc_nxt = s6_qc_nxt + 3'(s5_doe_r >= 18'(k * e2cd_pkg::DaysPerCent));
    end
  end
  assign min_prod = 25'(s5_r2_r) * 25'(e2cd_pkg::MinMul);

  // stage 7: corrected day count, second
  assign s7_t_nxt = s6_doe_r - 18'(s6_q4y_r) + 18'(s6_qc_r) - 18'(s6_last_r);
  assign sec_full = s6_r2_r - 12'(s6_min_r) * 12'd60;
  always_comb begin
    s7_hms_nxt.hour   = s6_hour_r;
    s7_hms_nxt.minute = s6_min_r;
    s7_hms_nxt.second = sec_full[5:0];
    s7_hms_nxt.wday   = s6_wd_r;
  end

  // stage 8: year of era
  assign yoe_prod = 37'(s7_t_r) * 37'(e2cd_pkg::YoeMul);

  // stage 9: days before year of era, march-based year
  assign cent = 2'(s8_yoe_r >= 9'd100) + 2'(s8_yoe_r >= 9'd200) + 2'(s8_yoe_r >= 9'd300);
  assign s9_yc_nxt = 18'(s8_yoe_r) * 18'd365 + 18'(s8_yoe_r[8:2]) - 18'(cent);
  assign s9_yr_nxt = 12'(s8_yoe_r) + 12'(s8_era_r) * e2cd_pkg::YearsPerEra;

  // stage 11: march-based month
  assign mon_arg  = 11'(s10_doy_r) * 11'd5 + 11'd2;
  assign mon_prod = 23'(mon_arg) * 23'(e2cd_pkg::MonMul);

  // stage 12: day, january-based month, year, packing
  assign day_full  = s11_doy_r - e2cd_pkg::month_start(s11_mp_r) + 9'd1;
  assign month_nxt = (s11_mp_r < 4'd10) ? s11_mp_r + 4'd2 : s11_mp_r - 4'd10;
  assign year_adj  = s11_yr_r + 12'(s11_mp_r >= 4'd10) - e2cd_pkg::YearBase;
  assign years_nxt = year_adj[8:0];
  assign out_tdata_nxt = s11_err_r ? '0 :
                         {2'b00, s11_hms_r.wday, s11_hms_r.second, s11_hms_r.minute,
                          s11_hms_r.hour, day_full[4:0], month_nxt, years_nxt};

  // payload registers
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_err_r <= s1_err_nxt;
      s1_sec_r <= in_tdata[32:0];
    end
    if (adv[2]) begin
      s2_err_r  <= s1_err_r;
      s2_sec_r  <= s1_sec_r;
      s2_days_r <= s2_days_nxt;
    end
    if (adv[3]) begin
      s3_err_r <= s2_err_r;
      s3_rem_r <= rem_full[16:0];
      s3_z_r   <= 20'(s2_days_r) + e2cd_pkg::DayShift;
      s3_dp4_r <= s3_dp4_nxt;
      s3_wdq_r <= wd_prod[e2cd_pkg::WdSh +: 14];
    end
    if (adv[4]) begin
      s4_err_r  <= s3_err_r;
      s4_rem_r  <= s3_rem_r;
      s4_z_r    <= s3_z_r;
      s4_era_r  <= s4_era_nxt;
      s4_hour_r <= hour_prod[e2cd_pkg::HourSh +: 5];
      s4_wd_r   <= wd_full[2:0];
    end
    if (adv[5]) begin
      s5_err_r  <= s4_err_r;
      s5_doe_r  <= doe_full[17:0];
      s5_era_r  <= s4_era_r;
      s5_r2_r   <= r2_full[11:0];
      s5_hour_r <= s4_hour_r;
      s5_wd_r   <= s4_wd_r;
    end
    if (adv[6]) begin
      s6_err_r  <= s5_err_r;
      s6_doe_r  <= s5_doe_r;
      s6_era_r  <= s5_era_r;
      s6_q4y_r  <= q4y_prod[e2cd_pkg::LeapSh +: 7];
      s6_qc_r   <= s6_qc_nxt;
      s6_last_r <= (s5_doe_r == e2cd_pkg::LastDoe);
      s6_r2_r   <= s5_r2_r;
      s6_min_r  <= min_prod[e2cd_pkg::MinSh +: 6];
      s6_hour_r <= s5_hour_r;
      s6_wd_r   <= s5_wd_r;
    end
    if (adv[7]) begin
      s7_err_r <= s6_err_r;
      s7_doe_r <= s6_doe_r;
      s7_era_r <= s6_era_r;
      s7_t_r   <= s7_t_nxt;
      s7_hms_r <= s7_hms_nxt;
    end
    if (adv[8]) begin
      s8_err_r <= s7_err_r;
      s8_doe_r <= s7_doe_r;
      s8_era_r <= s7_era_r;
      s8_yoe_r <= yoe_prod[e2cd_pkg::YoeSh +: 9];
      s8_hms_r <= s7_hms_r;
    end
    if (adv[9]) begin
      s9_err_r <= s8_err_r;
      s9_doe_r <= s8_doe_r;
      s9_yc_r  <= s9_yc_nxt;
      s9_yr_r  <= s9_yr_nxt;
      s9_hms_r <= s8_hms_r;
    end
    if (adv[10]) begin
      s10_err_r <= s9_err_r;
      s10_doy_r <= 9'(s9_doe_r - s9_yc_r);
      s10_yr_r  <= s9_yr_r;
      s10_hms_r <= s9_hms_r;
    end
    if (adv[11]) begin
      s11_err_r <= s10_err_r;
      s11_doy_r <= s10_doy_r;
      s11_mp_r  <= mon_prod[e2cd_pkg::MonSh +: 4];
      s11_yr_r  <= s10_yr_r;
      s11_hms_r <= s10_hms_r;
    end
    if (adv[12]) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= s11_err_r;
    end
  end

endmodule

// ===== hdl/e2cd_checker.sv =====
// port-level checks for epoch_to_civil_date_unit, attached by bind
// depends on e2cd_pkg
module e2cd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [e2cd_pkg::OutDataW-1:0] out_tdata,
  input logic                          out_tuser
);

  // a waiting result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // a rejected epoch carries an all-zero date and time
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("out-of-range result has non-zero fields");

  // a converted result has every field but the year within its calendar range
  a_fields_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[12:9] <= 4'd11 && out_tdata[17:13] != 5'd0 &&
      out_tdata[22:18] <= 5'd23 && out_tdata[28:23] <= 6'd59 &&
      out_tdata[34:29] <= 6'd59 && out_tdata[37:35] <= 3'd6 &&
      out_tdata[39:38] == 2'b00)
    else $error("converted result out of calendar range");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

bind epoch_to_civil_date_unit e2cd_checker u_e2cd_checker (.*);

// ===== dv/tb_top.sv =====
// self-checking bench for epoch_to_civil_date_unit: epoch seconds in, civil date out
// depends on e2cd_pkg and the unit; the date predictor lives in this file
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic       status;
    logic [8:0] years;
    logic [3:0] month;
    logic [4:0] mday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
  } civil_date_t;

  localparam logic [e2cd_pkg::CfgW-1:0] MaxEpochFull = {e2cd_pkg::CfgW{1'b1}};

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [e2cd_pkg::InDataW-1:0]  in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [e2cd_pkg::OutDataW-1:0] out_tdata;
  logic                          out_tuser;
  logic                          cfg_we     = 1'b0;
  logic [e2cd_pkg::CfgW-1:0]     cfg_wdata  = '0;

  // bench-side state
  logic [e2cd_pkg::InDataW-1:0] pending_epochs[$];
  civil_date_t                  expected_dates[$];
  logic [e2cd_pkg::CfgW-1:0]    model_max_epoch = e2cd_pkg::MaxEpochReset;
  logic                         in_taken        = 1'b0;
  int                           queued_count    = 0;
  int                           accepted_count  = 0;
  int                           fail_count      = 0;
  int                           send_idle_pct   = 0;
  int                           recv_stall_pct  = 0;

  epoch_to_civil_date_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // civil date predictor, days-from-civil inverse on 64-bit unsigned values
  function automatic civil_date_t predict_civil_date(
      input logic [63:0] epoch, input logic [e2cd_pkg::CfgW-1:0] max_epoch);
    civil_date_t     res;
    longint unsigned days, rem, z, era, doe, yoe, yr, doy, mp, d, m;
    res = '0;
    if (epoch[63] || epoch > {31'b0, max_epoch}) begin
      res.status = 1'b1;
      return res;
    end
    days = epoch / e2cd_pkg::SecsPerDay;
    rem  = epoch % e2cd_pkg::SecsPerDay;
    z    = days + e2cd_pkg::DayShift;
    era  = z / e2cd_pkg::DaysPerEra;
    doe  = z - era * e2cd_pkg::DaysPerEra;
    yoe  = (doe - doe / 1460 + doe / e2cd_pkg::DaysPerCent - doe / e2cd_pkg::LastDoe) / 365;
    yr   = yoe + era * e2cd_pkg::YearsPerEra;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    d    = doy - (153 * mp + 2) / 5 + 1;
    m    = (mp < 10) ? mp + 3 : mp - 9;
    if (m <= 2) yr = yr + 1;
    res.years  = 9'(yr - e2cd_pkg::YearBase);
    res.month  = 4'(m - 1);
    res.mday   = 5'(d);
    res.hour   = 5'(rem / e2cd_pkg::SecsPerHour);
    res.minute = 6'((rem % e2cd_pkg::SecsPerHour) / 60);
    res.second = 6'(rem % 60);
    res.wday   = 3'((days + 4) % 7);
    return res;
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // input driver: next epoch or idle once the current one has gone
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_taken || !in_tvalid) begin
      if (pending_epochs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_epochs.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken <= 1'b0;
  end

  // result back-pressure
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: register shadow, input transfers to predictions, result checks
  always @(posedge clk) begin
    civil_date_t exp_d;
    if (rst_n) begin
      if (cfg_we) model_max_epoch <= cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (expected_dates.size() == 0) begin
          $error("result transfer with no expected date pending: tdata %h", out_tdata);
          fail_count++;
        end else begin
          exp_d = expected_dates.pop_front();
          check_field("status",           exp_d.status, out_tuser);
          check_field("years_since_1900", exp_d.years,  out_tdata[8:0]);
          check_field("month_index",      exp_d.month,  out_tdata[12:9]);
          check_field("day_of_month",     exp_d.mday,   out_tdata[17:13]);
          check_field("hour_of_day",      exp_d.hour,   out_tdata[22:18]);
          check_field("minute_of_hour",   exp_d.minute, out_tdata[28:23]);
          check_field("second_of_minute", exp_d.second, out_tdata[34:29]);
          check_field("weekday",          exp_d.wday,   out_tdata[37:35]);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_dates.push_back(predict_civil_date(in_tdata, model_max_epoch));
        accepted_count++;
        in_taken <= 1'b1;
      end
    end
  end

  task automatic queue_epoch(input logic [63:0] epoch);
    pending_epochs.push_back(epoch);
    queued_count++;
  endtask

  // mostly accepted epochs, with boundaries around the maximum and out-of-range noise
  function automatic logic [63:0] random_epoch(input logic [e2cd_pkg::CfgW-1:0] max_epoch);
    logic [63:0] raw;
    logic [63:0] lim;
    raw = {$urandom, $urandom};
    lim = {31'b0, max_epoch};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return raw % (lim + 1);
      5:       return (raw % (lim / e2cd_pkg::SecsPerDay + 1)) * e2cd_pkg::SecsPerDay
                      + ($urandom_range(0, 1) ? e2cd_pkg::SecsPerDay - 1 : 0);
      6:       return lim - $urandom_range(0, 3);
      7:       return lim + $urandom_range(1, 3);
      8:       return {1'b1, raw[62:0]};
      default: return raw;
    endcase
  endfunction

  task automatic queue_random(input int count);
    repeat (count) queue_epoch(random_epoch(model_max_epoch));
  endtask

  // hold off until every queued epoch has gone in and every date has come out
  task automatic drain;
    while (accepted_count != queued_count || expected_dates.size() != 0)
      @(negedge clk);
    repeat (e2cd_pkg::Stages + 4) @(negedge clk);
  endtask

  task automatic write_max_epoch(input logic [e2cd_pkg::CfgW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // run-time limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [63:0] rnd_word;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default maximum, no idling: epoch origin, day and leap edges, sign extremes
    set_idling(0, 0);
    queue_epoch(64'd0);
    queue_epoch(64'd86399);
    queue_epoch(64'd86400);
    queue_epoch(64'd946684799);
    queue_epoch(64'd951782400);
    queue_epoch(64'd951868800);
    queue_epoch(64'd1709164800);
    queue_epoch(64'd2147483647);
    queue_epoch(64'd4102444799);
    queue_epoch(64'd4102444800);
    queue_epoch({64{1'b1}});
    queue_epoch({1'b1, 63'b0});
    queue_epoch({1'b0, {63{1'b1}}});
    queue_random(200);
    drain();

    // widest maximum, sender idling: end of 2100 february, top of the range
    write_max_epoch(MaxEpochFull);
    set_idling(46, 0);
    queue_epoch({31'b0, MaxEpochFull});
    queue_epoch({31'b0, MaxEpochFull} + 1);
    queue_epoch(64'd4102444800);
    queue_epoch(64'd4107542399);
    queue_epoch(64'd4107542400);
    queue_random(300);
    drain();

    // zero maximum, receiver stalling: only the origin converts
    write_max_epoch('0);
    set_idling(0, 46);
    queue_epoch(64'd0);
    queue_epoch(64'd1);
    queue_epoch({64{1'b1}});
    queue_random(100);
    drain();

    // random maximum, both sides idling
    rnd_word = {$urandom, $urandom};
    write_max_epoch(rnd_word[e2cd_pkg::CfgW-1:0]);
    set_idling(12, 12);
    queue_random(300);
    drain();

    // random maximum again, receiver stalling
    rnd_word = {$urandom, $urandom};
    write_max_epoch(rnd_word[e2cd_pkg::CfgW-1:0]);
    set_idling(0, 46);
    queue_random(300);
    drain();

    // back to the reset maximum, both sides idling
    write_max_epoch(e2cd_pkg::MaxEpochReset);
    set_idling(12, 12);
    queue_random(300);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/e2cd_pkg.sv
hdl/epoch_to_civil_date_unit.sv
hdl/e2cd_checker.sv
dv/tb_top.sv
